FILE: hdl/rmbd_pkg.sv
package rmbd_pkg;

  localparam int MAX_DIM_DEF = 128;

  localparam int CFG_W   = 8;
  localparam int COORD_W = 7;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 4;
  localparam int CNT_W   = 4;
  // 9 samples of 255 plus the rounding half still fit in 12 bits
  localparam int SUM_W   = 12;
  localparam int RCP_W   = 17;
  localparam int RCP_SH  = 16;
  localparam int PROD_W  = SUM_W + RCP_W;

  localparam logic [CFG_W-1:0] SIZE_RESET = 8'd128;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic CFG_SRC_WIDTH  = 1'b0;
  localparam logic CFG_SRC_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef logic [NUM_CH-1:0][SUM_W-1:0] ch_sums_t;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [CFG_W-1:0]   size_w;
    logic [CFG_W-1:0]   size_h;
  } scan_cmd_t;

  typedef struct packed {
    logic             done;
    logic             err;
    logic [CNT_W-1:0] count;
  } scan_stat_t;

  // ceil(2^16 / n); exact for every dividend below 2^12 and n up to 9
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] r;
    unique case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/rmbd_stream_if.sv
interface rmbd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [rmbd_pkg::COORD_W-1:0] pos_x;
  logic [rmbd_pkg::COORD_W-1:0] pos_y;
  logic [rmbd_pkg::CH_W-1:0]  in_red;
  logic [rmbd_pkg::CH_W-1:0]  in_green;
  logic [rmbd_pkg::CH_W-1:0]  in_blue;
  logic [rmbd_pkg::CH_W-1:0]  in_alpha;

  modport source (output valid, op, pos_x, pos_y, in_red, in_green, in_blue, in_alpha,
                  input ready);
  modport sink (input valid, op, pos_x, pos_y, in_red, in_green, in_blue, in_alpha,
                output ready);
endinterface

interface rmbd_out_if;
  logic                        valid;
  logic                        ready;
  logic [rmbd_pkg::CH_W-1:0]   out_red;
  logic [rmbd_pkg::CH_W-1:0]   out_green;
  logic [rmbd_pkg::CH_W-1:0]   out_blue;
  logic [rmbd_pkg::CH_W-1:0]   out_alpha;
  logic [rmbd_pkg::CNT_W-1:0]  sample_total;
  logic                        coord_error;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, sample_total,
                  coord_error, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, sample_total,
                coord_error, output ready);
endinterface

FILE: hdl/rmbd_pixel_store.sv
module rmbd_pixel_store #(
  parameter  int MAX_DIM = rmbd_pkg::MAX_DIM_DEF,
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  rmbd_pkg::pixel_t     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output rmbd_pkg::pixel_t     rdata
);
  rmbd_pkg::pixel_t mem [DEPTH];
  rmbd_pkg::pixel_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: hdl/rmbd_footprint_scan.sv
module rmbd_footprint_scan #(
  parameter  int MAX_DIM = rmbd_pkg::MAX_DIM_DEF,
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rmbd_pkg::scan_cmd_t  cmd,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  rmbd_pkg::pixel_t     rd_data,
  output rmbd_pkg::scan_stat_t stat,
  output rmbd_pkg::ch_sums_t   sums
);
  localparam int SW    = rmbd_pkg::CFG_W;

  logic [SW-1:0] nw, nh;
  logic          err;
  logic [1:0]    nx, ny;

  logic [SW-1:0] x0_r, y0_r;
  logic [1:0]    nx_r, ny_r, cx_r, cy_r;
  logic          scanning_r, rvalid_r, last_r, done_r, err_r;
  logic [rmbd_pkg::CNT_W-1:0] count_r;
  rmbd_pkg::ch_sums_t sums_r;

  logic          last_rd;
  logic [SW-1:0] row, col;
  logic [31:0]   addr_full;

  // next level size is max(size/2, 1)
  assign nw  = (cmd.size_w[SW-1:1] == '0) ? SW'(1) : {1'b0, cmd.size_w[SW-1:1]};
  assign nh  = (cmd.size_h[SW-1:1] == '0) ? SW'(1) : {1'b0, cmd.size_h[SW-1:1]};
  assign err = (SW'(cmd.pos_x) >= nw) || (SW'(cmd.pos_y) >= nh);

  // footprint starts at 2d; odd sizes widen the last footprint to three
  always_comb begin
    if (cmd.size_w == SW'(1)) begin
      nx = 2'd1;
    end else if (cmd.size_w[0] && (SW'(cmd.pos_x) + SW'(1) == nw)) begin
      nx = 2'd3;
    end else begin
      nx = 2'd2;
    end
    if (cmd.size_h == SW'(1)) begin
      ny = 2'd1;
    end else if (cmd.size_h[0] && (SW'(cmd.pos_y) + SW'(1) == nh)) begin
      ny = 2'd3;
    end else begin
      ny = 2'd2;
    end
  end

  assign last_rd   = (cx_r == nx_r - 2'd1) && (cy_r == ny_r - 2'd1);
  assign row       = y0_r + SW'(cy_r);
  assign col       = x0_r + SW'(cx_r);
  assign addr_full = 32'(row) * 32'(MAX_DIM) + 32'(col);
  assign rd_addr   = addr_full[AW-1:0];
  assign rd_en     = scanning_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
      rvalid_r   <= 1'b0;
      last_r     <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      rvalid_r <= scanning_r;
      last_r   <= scanning_r && last_rd;
      done_r   <= (cmd.start && err) || (rvalid_r && last_r);
      if (cmd.start) begin
        scanning_r <= !err;
      end else if (scanning_r && last_rd) begin
        scanning_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x0_r    <= {cmd.pos_x, 1'b0};
      y0_r    <= {cmd.pos_y, 1'b0};
      nx_r    <= nx;
      ny_r    <= ny;
      cx_r    <= 2'd0;
      cy_r    <= 2'd0;
      err_r   <= err;
      count_r <= '0;
      sums_r  <= '0;
    end else begin
      if (scanning_r) begin
        if (cx_r == nx_r - 2'd1) begin
          cx_r <= 2'd0;
          cy_r <= cy_r + 2'd1;
        end else begin
          cx_r <= cx_r + 2'd1;
        end
      end
      if (rvalid_r) begin
        count_r   <= count_r + rmbd_pkg::CNT_W'(1);
        sums_r[0] <= sums_r[0] + rmbd_pkg::SUM_W'(rd_data.red);
        sums_r[1] <= sums_r[1] + rmbd_pkg::SUM_W'(rd_data.green);
        sums_r[2] <= sums_r[2] + rmbd_pkg::SUM_W'(rd_data.blue);
        sums_r[3] <= sums_r[3] + rmbd_pkg::SUM_W'(rd_data.alpha);
      end
    end
  end

  assign stat.done  = done_r;
  assign stat.err   = err_r;
  assign stat.count = count_r;
  assign sums       = sums_r;
endmodule

FILE: hdl/rmbd_avg_div.sv
module rmbd_avg_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rmbd_pkg::scan_stat_t acc,
  input  rmbd_pkg::ch_sums_t   sums,
  output rmbd_pkg::scan_stat_t res,
  output rmbd_pkg::pixel_t     avg
);
  localparam int CH_IW = $clog2(rmbd_pkg::NUM_CH + 1);

  logic                          busy_r, done_r, err_r;
  logic [CH_IW-1:0]              ch_r;
  logic [rmbd_pkg::CNT_W-1:0]    n_r;
  rmbd_pkg::ch_sums_t            sums_r;
  logic [rmbd_pkg::PROD_W-1:0]   prod_r;
  logic [rmbd_pkg::NUM_CH-1:0][rmbd_pkg::CH_W-1:0] q_r;

  logic [rmbd_pkg::SUM_W-1:0]    operand;
  logic [1:0]                    ch_sel, ch_prev;

  assign ch_sel  = ch_r[1:0];
  assign ch_prev = 2'(ch_r - CH_IW'(1));
  // round half up: (sum + n/2) / n, the division as a reciprocal multiply
  assign operand = sums_r[ch_sel] + rmbd_pkg::SUM_W'(n_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (ch_r == CH_IW'(rmbd_pkg::NUM_CH));
      if (acc.done) begin
        busy_r <= 1'b1;
      end else if (ch_r == CH_IW'(rmbd_pkg::NUM_CH)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc.done) begin
      ch_r   <= '0;
      n_r    <= acc.count;
      err_r  <= acc.err;
      sums_r <= sums;
    end else if (busy_r) begin
      ch_r <= ch_r + CH_IW'(1);
      if (ch_r < CH_IW'(rmbd_pkg::NUM_CH)) begin
        prod_r <= rmbd_pkg::PROD_W'(operand) * rmbd_pkg::PROD_W'(rmbd_pkg::recip(n_r));
      end
      if (ch_r != '0) begin
        q_r[ch_prev] <= prod_r[rmbd_pkg::RCP_SH +: rmbd_pkg::CH_W];
      end
    end
  end

  assign res.done  = done_r;
  assign res.err   = err_r;
  assign res.count = n_r;
  assign avg.red   = q_r[0];
  assign avg.green = q_r[1];
  assign avg.blue  = q_r[2];
  assign avg.alpha = q_r[3];
endmodule

FILE: hdl/rgba_mip_box_downsample_core.sv
// Write item: accepted while idle, stored at the edge of its transfer, no result.
// Compute item with n footprint samples (1 to 9): the store is read one sample a cycle,
// then the shared multiplier averages the four channels in turn, and the result register
// fills once it is free; the next item is taken in the cycle after that, not before.
// A coordinate outside the next level skips the reads.
// Synchronous active-low reset; sizes return to 128, the pixel store is not cleared.
module rgba_mip_box_downsample_core #(
  parameter int MAX_DIM = rmbd_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rmbd_in_if.sink                       in_chan,
  rmbd_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rmbd_pkg::CFG_W-1:0]    cfg_data
);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = rmbd_pkg::CFG_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [SW-1:0] src_width_r, src_height_r;
  logic [SW-1:0] size_w, size_h;

  logic                 in_xfer, mem_we, out_load;
  logic [31:0]          waddr_full;
  rmbd_pkg::pixel_t     wpix, rd_data, avg;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  rmbd_pkg::scan_cmd_t  scan_cmd;
  rmbd_pkg::scan_stat_t scan_st, div_st;
  rmbd_pkg::ch_sums_t   sums;

  logic                        out_valid_r;
  rmbd_pkg::pixel_t            out_pix_r;
  logic [rmbd_pkg::CNT_W-1:0]  out_cnt_r;
  logic                        out_err_r;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= rmbd_pkg::SIZE_RESET;
      src_height_r <= rmbd_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmbd_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_data;
        rmbd_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_width_r == '0) begin
      size_w = SW'(1);
    end else if (32'(src_width_r) > MAX_DIM) begin
      size_w = SW'(MAX_DIM);
    end else begin
      size_w = src_width_r;
    end
    if (src_height_r == '0) begin
      size_h = SW'(1);
    end else if (32'(src_height_r) > MAX_DIM) begin
      size_h = SW'(MAX_DIM);
    end else begin
      size_h = src_height_r;
    end
  end

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign mem_we        = in_xfer && (in_chan.op == rmbd_pkg::OP_WRITE) &&
                         (32'(in_chan.pos_x) < MAX_DIM) && (32'(in_chan.pos_y) < MAX_DIM);
  assign waddr_full    = 32'(in_chan.pos_y) * 32'(MAX_DIM) + 32'(in_chan.pos_x);
  assign wpix.red      = in_chan.in_red;
  assign wpix.green    = in_chan.in_green;
  assign wpix.blue     = in_chan.in_blue;
  assign wpix.alpha    = in_chan.in_alpha;

  assign scan_cmd.start  = in_xfer && (in_chan.op == rmbd_pkg::OP_COMPUTE);
  assign scan_cmd.pos_x  = in_chan.pos_x;
  assign scan_cmd.pos_y  = in_chan.pos_y;
  assign scan_cmd.size_w = size_w;
  assign scan_cmd.size_h = size_h;

  rmbd_pixel_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr_full[AW-1:0]),
    .wdata (wpix),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rmbd_footprint_scan #(.MAX_DIM(MAX_DIM)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (scan_cmd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .stat    (scan_st),
    .sums    (sums)
  );

  rmbd_avg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (scan_st),
    .sums  (sums),
    .res   (div_st),
    .avg   (avg)
  );

  assign out_load = (state_r == S_HOLD) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (scan_cmd.start) state_nxt = S_SCAN;
      S_SCAN: if (scan_st.done)   state_nxt = S_DIV;
      S_DIV:  if (div_st.done)    state_nxt = S_HOLD;
      S_HOLD: if (out_load)       state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r <= avg;
      out_cnt_r <= div_st.count;
      out_err_r <= div_st.err;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_red      = out_pix_r.red;
  assign out_chan.out_green    = out_pix_r.green;
  assign out_chan.out_blue     = out_pix_r.blue;
  assign out_chan.out_alpha    = out_pix_r.alpha;
  assign out_chan.sample_total = out_cnt_r;
  assign out_chan.coord_error  = out_err_r;

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_st.done |-> state_r == S_SCAN)
    else $error("footprint scan finished outside the scan phase");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_DIV)
    else $error("average finished outside the divide phase");

  a_store_reads_not_during_write: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !mem_we && state_r == S_SCAN)
    else $error("store read issued outside the scan phase");

  a_error_has_no_samples: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && div_st.err |-> div_st.count == '0 && avg == '0)
    else $error("coordinate error result carries samples");

  a_load_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !div_st.err |-> div_st.count != '0 && div_st.count <= 4'd9)
    else $error("sample count out of range");
endmodule

FILE: verif/tb_rgba_mip_box_downsample_core.sv
module tb_rgba_mip_box_downsample_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM          = rmbd_pkg::MAX_DIM_DEF;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 25;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 150;

  typedef struct packed {
    logic                         op;
    logic [rmbd_pkg::COORD_W-1:0] x;
    logic [rmbd_pkg::COORD_W-1:0] y;
    rmbd_pkg::pixel_t             color;
  } mip_item_t;

  typedef struct {
    rmbd_pkg::pixel_t           avg;
    logic [rmbd_pkg::CNT_W-1:0] count;
    logic                       err;
  } mip_result_t;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic                       cfg_index = rmbd_pkg::CFG_SRC_WIDTH;
  logic [rmbd_pkg::CFG_W-1:0] cfg_data  = '0;

  rmbd_in_if  in_chan();
  rmbd_out_if out_chan();

  rgba_mip_box_downsample_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  mip_item_t   pending_items[$];
  mip_result_t expected_pixels[$];

  // mirror of the block state, advanced on input transfers and register writes
  rmbd_pkg::pixel_t           mirror_store[DIM*DIM];
  logic [rmbd_pkg::CFG_W-1:0] mirror_w = rmbd_pkg::SIZE_RESET;
  logic [rmbd_pkg::CFG_W-1:0] mirror_h = rmbd_pkg::SIZE_RESET;

  // stimulus side view: which store entries will have been written
  bit planned[DIM*DIM];
  int plan_w = DIM;
  int plan_h = DIM;

  int        idle_pct     = 27;
  int        errors       = 0;
  int        results_seen = 0;
  int        stall_cycles = 0;
  int        hold_left    = 0;
  bit        hold_done    = 0;
  int        items_queued = 0;
  logic      in_took      = 1'b0;
  mip_item_t drive_item;

  function automatic int eff_size(input logic [rmbd_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  function automatic int half_size(input int v);
    return (v / 2 < 1) ? 1 : v / 2;
  endfunction

  function automatic mip_result_t box_average(input mip_item_t it);
    mip_result_t r;
    int w, h, nw, nh, x0, x1, y0, y1, n;
    int sum[4];
    rmbd_pkg::pixel_t p;
    r.avg   = '0;
    r.count = '0;
    r.err   = 1'b0;
    w  = eff_size(mirror_w);
    h  = eff_size(mirror_h);
    nw = half_size(w);
    nh = half_size(h);
    if (int'(it.x) >= nw || int'(it.y) >= nh) begin
      r.err = 1'b1;
      return r;
    end
    x0 = int'(it.x) * w / nw;
    x1 = (int'(it.x) + 1) * w / nw;
    y0 = int'(it.y) * h / nh;
    y1 = (int'(it.y) + 1) * h / nh;
    n = 0;
    sum = '{0, 0, 0, 0};
    for (int yy = y0; yy < y1; yy++) begin
      for (int xx = x0; xx < x1; xx++) begin
        p = mirror_store[yy*DIM + xx];
        sum[0] += int'(p.red);
        sum[1] += int'(p.green);
        sum[2] += int'(p.blue);
        sum[3] += int'(p.alpha);
        n++;
      end
    end
    r.avg.red   = rmbd_pkg::CH_W'((sum[0] + n / 2) / n);
    r.avg.green = rmbd_pkg::CH_W'((sum[1] + n / 2) / n);
    r.avg.blue  = rmbd_pkg::CH_W'((sum[2] + n / 2) / n);
    r.avg.alpha = rmbd_pkg::CH_W'((sum[3] + n / 2) / n);
    r.count     = rmbd_pkg::CNT_W'(n);
    return r;
  endfunction

  task automatic push_write(input int x, input int y, input rmbd_pkg::pixel_t c);
    mip_item_t it;
    it.op    = rmbd_pkg::OP_WRITE;
    it.x     = rmbd_pkg::COORD_W'(x);
    it.y     = rmbd_pkg::COORD_W'(y);
    it.color = c;
    pending_items = {pending_items, it};
    planned[y*DIM + x] = 1'b1;
    items_queued++;
  endtask

  // fills any footprint pixel not yet written, then queues the compute
  task automatic push_compute(input int x, input int y);
    mip_item_t it;
    int nw, nh;
    nw = half_size(plan_w);
    nh = half_size(plan_h);
    if (x < nw && y < nh) begin
      for (int yy = y * plan_h / nh; yy < (y + 1) * plan_h / nh; yy++)
        for (int xx = x * plan_w / nw; xx < (x + 1) * plan_w / nw; xx++)
          if (!planned[yy*DIM + xx]) push_write(xx, yy, rmbd_pkg::pixel_t'($urandom));
    end
    it.op    = rmbd_pkg::OP_COMPUTE;
    it.x     = rmbd_pkg::COORD_W'(x);
    it.y     = rmbd_pkg::COORD_W'(y);
    it.color = rmbd_pkg::pixel_t'($urandom);
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  task automatic set_size(input logic idx, input logic [rmbd_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rmbd_pkg::CFG_SRC_WIDTH) plan_w = eff_size(value);
    else plan_h = eff_size(value);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_chan.valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [rmbd_pkg::CFG_W-1:0] w,
                           input logic [rmbd_pkg::CFG_W-1:0] h,
                           input int n_items, input int idle);
    int start, nw, nh, r;
    set_size(rmbd_pkg::CFG_SRC_WIDTH, w);
    set_size(rmbd_pkg::CFG_SRC_HEIGHT, h);
    idle_pct = idle;
    nw = half_size(plan_w);
    nh = half_size(plan_h);
    start = items_queued;
    while (items_queued - start < n_items) begin
      r = $urandom_range(99);
      if (r < 20) begin
        push_write($urandom_range(plan_w - 1), $urandom_range(plan_h - 1),
                   rmbd_pkg::pixel_t'($urandom));
      end else if (r < 32) begin
        push_write($urandom_range(DIM - 1), $urandom_range(DIM - 1),
                   rmbd_pkg::pixel_t'($urandom));
      end else if (r < 42) begin
        // destination outside the next level on one or both axes
        if ($urandom_range(1))
          push_compute($urandom_range(DIM - 1, nw), $urandom_range(DIM - 1));
        else
          push_compute($urandom_range(DIM - 1), $urandom_range(DIM - 1, nh));
      end else begin
        push_compute($urandom_range(nw - 1), $urandom_range(nh - 1));
      end
    end
    drain();
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_took) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drive_item = pending_items.pop_front();
        in_chan.op       <= drive_item.op;
        in_chan.pos_x    <= drive_item.x;
        in_chan.pos_y    <= drive_item.y;
        in_chan.in_red   <= drive_item.color.red;
        in_chan.in_green <= drive_item.color.green;
        in_chan.in_blue  <= drive_item.color.blue;
        in_chan.in_alpha <= drive_item.color.alpha;
        in_chan.valid    <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off so the block backs up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      errors++;
    end
  endtask

  // input transfers and register writes advance the mirror
  always @(posedge clk) begin
    mip_item_t   it;
    mip_result_t res;
    in_took <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && cfg_we) begin
      if (cfg_index == rmbd_pkg::CFG_SRC_WIDTH) mirror_w = cfg_data;
      else mirror_h = cfg_data;
    end
    if (rst_n && in_chan.valid && in_chan.ready) begin
      it.op          = in_chan.op;
      it.x           = in_chan.pos_x;
      it.y           = in_chan.pos_y;
      it.color.red   = in_chan.in_red;
      it.color.green = in_chan.in_green;
      it.color.blue  = in_chan.in_blue;
      it.color.alpha = in_chan.in_alpha;
      if (it.op == rmbd_pkg::OP_WRITE) begin
        mirror_store[int'(it.y)*DIM + int'(it.x)] = it.color;
      end else begin
        res = box_average(it);
        expected_pixels = {expected_pixels, res};
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    mip_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        $error("result transfer with no pending expectation");
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red", int'(want.avg.red), int'(out_chan.out_red));
        check_field("out_green", int'(want.avg.green), int'(out_chan.out_green));
        check_field("out_blue", int'(want.avg.blue), int'(out_chan.out_blue));
        check_field("out_alpha", int'(want.avg.alpha), int'(out_chan.out_alpha));
        check_field("sample_total", int'(want.count), int'(out_chan.sample_total));
        check_field("coord_error", int'(want.err), int'(out_chan.coord_error));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles", STALL_LIMIT);
      $display("** rgba_mip_box_downsample_core: FAILED **");
      $finish;
    end
  end

  initial begin
    in_chan.valid    = 1'b0;
    in_chan.op       = rmbd_pkg::OP_WRITE;
    in_chan.pos_x    = '0;
    in_chan.pos_y    = '0;
    in_chan.in_red   = '0;
    in_chan.in_green = '0;
    in_chan.in_blue  = '0;
    in_chan.in_alpha = '0;
    out_chan.ready   = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset sizes: corners, extreme channel values, out-of-level destinations
    push_write(0, 0, 32'h0000_0000);
    push_write(DIM - 1, DIM - 1, 32'hFFFF_FFFF);
    push_write(DIM - 1, 0, 32'hFF00_FF00);
    push_compute(0, 0);
    push_compute(DIM / 2 - 1, DIM / 2 - 1);
    push_compute(DIM / 2 - 1, 0);
    push_compute(DIM / 2, 0);
    push_compute(0, DIM / 2);
    push_compute(DIM - 1, DIM - 1);
    drain();

    run_phase(8'd128, 8'd128, 100, 27);
    run_phase(8'd3,   8'd3,    60, 27);
    run_phase(8'd1,   8'd1,    40, 27);
    run_phase(8'd0,   8'd0,    40, 27);
    run_phase(8'd255, 8'd200, 100, 27);
    run_phase(8'd128, 8'd1,    80, 27);
    run_phase(8'd1,   8'd128,  80, 27);
    run_phase(8'd2,   8'd5,    40, 27);
    // back-to-back stretch: neither side idles
    run_phase(8'($urandom_range(4, 24)), 8'($urandom_range(4, 24)), 120, 0);
    for (int i = 0; i < 5; i++) begin
      if (i == 2)
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 100, 27);
      else
        run_phase(8'($urandom_range(1, 24)), 8'($urandom_range(1, 24)), 100, 27);
    end

    if (errors == 0)
      $display("** rgba_mip_box_downsample_core: PASSED **");
    else
      $display("** rgba_mip_box_downsample_core: FAILED **");
    $finish;
  end

endmodule
